// File: hdl/rtbc_pkg.sv
// Shared constants, status codes and decode/encode helpers for the ranging
// timing budget calculator. No dependencies.
package rtbc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LOW   = 2'd1,
    ST_OVER  = 2'd2,
    ST_LARGE = 2'd3
  } status_e;

  localparam logic [21:0] MinBudgetUs  = 22'd20000;
  localparam logic [21:0] MaxBudgetUs  = 22'd4000000;
  localparam logic [31:0] CurFixedUs   = 32'd2870;   // start 1910 + end 960
  localparam logic [31:0] UsedFixedUs  = 32'd2830;   // start 1320 + end 960 + final 550
  localparam logic [31:0] TccUs        = 32'd590;
  localparam logic [31:0] DssUs        = 32'd690;
  localparam logic [31:0] MsrcUs       = 32'd660;
  localparam logic [31:0] PreUs        = 32'd660;
  localparam logic [31:0] FinalUs      = 32'd550;
  // floor(x / 1000) = (x * Div1000Magic) >> 38 for any 32-bit x
  localparam logic [31:0] Div1000Magic = 32'h10624DD3;
  localparam int          DivStages    = 32;

  // Macro period in ns: round(2304 * 1655 * period / 1000), period = 2k,
  // k = code + 1 kept in 7 bits so the top code wraps to zero.
  // 7626.24 * k = 7626 * k + round(0.24 * k); the fraction via a reciprocal.
  function automatic logic [19:0] macro_ns(logic [6:0] code);
    logic [6:0]  k;
    logic [11:0] x;
    logic [24:0] r;
    logic [19:0] base;
    k    = code + 7'd1;
    x    = 12'(k) * 12'd24 + 12'd50;
    r    = 25'(x) * 25'd5243;
    base = 20'(k) * 20'd7626;
    return base + 20'(r[24:19]);
  endfunction

  // Encoded timeout to macro clocks: (mantissa << shift) + 1, 16-bit wraps
  function automatic logic [15:0] decode_word(logic [15:0] w);
    logic [15:0] v;
    v = (w[15:8] < 8'd16) ? (16'(w[7:0]) << w[11:8]) : 16'd0;
    return v + 16'd1;
  endfunction

  // Macro clocks to encoded timeout
  function automatic logic [15:0] encode_word(logic [15:0] m);
    logic [15:0] ls;
    logic [7:0]  ms;
    logic [15:0] sh;
    ls = m - 16'd1;
    ms = 8'd0;
    for (int i = 8; i < 16; i++) begin
      if (ls[i]) begin
        ms = 8'(i - 7);
      end
    end
    sh = ls >> ms[3:0];
    return (m == 16'd0) ? 16'd0 : {ms, sh[7:0]};
  endfunction

endpackage

// File: hdl/ranging_timing_budget_calc_unit.sv
// Top level of the ranging timing budget calculator.
// Depends on rtbc_pkg for constants, status codes and word helpers.
//
// Fully pipelined: one transfer accepted per cycle unless the output stalls;
// each result passes five arithmetic stages, a 32-stage bit-per-stage
// restoring divider for the microseconds-to-macro-clocks step, and the
// output register. A stall on the output freezes the whole pipeline;
// in_stall_o is raised only while a finished result is held by out_stall_i.
module ranging_timing_budget_calc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [21:0] requested_budget_us_i,
  input  logic [7:0]  sequence_enables_i,
  input  logic [6:0]  pre_vcsel_code_i,
  input  logic [6:0]  final_vcsel_code_i,
  input  logic [7:0]  msrc_timeout_code_i,
  input  logic [15:0] pre_timeout_word_i,
  input  logic [15:0] final_timeout_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        write_valid_o,
  output logic [15:0] new_final_word_o,
  output logic [31:0] current_budget_us_o
);

  localparam int NDiv = rtbc_pkg::DivStages;

  // Sideband carried alongside the divider
  typedef struct packed {
    rtbc_pkg::status_e status;
    logic              wr;
    logic              pre;
    logic              mp_zero;
    logic [15:0]       pre_mclks;
    logic [19:0]       mp;
    logic [31:0]       cur;
  } sb_t;

  logic adv;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: decode ----------------
  logic        v1_q;
  logic [21:0] req1_q;
  logic        tcc1_q, dss1_q, msrc1_q, pre1_q, fin1_q;
  logic [19:0] pmp1_q, fmp1_q;
  logic [8:0]  step1_q;
  logic [15:0] pmc1_q, fmc1_q;
  logic [15:0] pmc1_d, fmc1_d;

  always_comb begin
    pmc1_d = rtbc_pkg::decode_word(pre_timeout_word_i);
    fmc1_d = rtbc_pkg::decode_word(final_timeout_word_i);
    if (sequence_enables_i[6]) begin
      fmc1_d = fmc1_d - pmc1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req1_q  <= requested_budget_us_i;
      tcc1_q  <= sequence_enables_i[4];
      dss1_q  <= sequence_enables_i[3];
      msrc1_q <= sequence_enables_i[2];
      pre1_q  <= sequence_enables_i[6];
      fin1_q  <= sequence_enables_i[7];
      pmp1_q  <= rtbc_pkg::macro_ns(pre_vcsel_code_i);
      fmp1_q  <= rtbc_pkg::macro_ns(final_vcsel_code_i);
      step1_q <= 9'(msrc_timeout_code_i) + 9'd1;
      pmc1_q  <= pmc1_d;
      fmc1_q  <= fmc1_d;
    end
  end

  // ---------------- stage 2: mclks * macro period + half ----------------
  logic        v2_q;
  logic [21:0] req2_q;
  logic        tcc2_q, dss2_q, msrc2_q, pre2_q, fin2_q;
  logic [19:0] fmp2_q;
  logic [15:0] pmc2_q;
  logic [31:0] xs2_q, xp2_q, xf2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req2_q  <= req1_q;
      tcc2_q  <= tcc1_q;
      dss2_q  <= dss1_q;
      msrc2_q <= msrc1_q;
      pre2_q  <= pre1_q;
      fin2_q  <= fin1_q;
      fmp2_q  <= fmp1_q;
      pmc2_q  <= pmc1_q;
      xs2_q   <= 32'(29'(step1_q) * 29'(pmp1_q)) + 32'(pmp1_q >> 1);
      xp2_q   <= 32'(36'(pmc1_q) * 36'(pmp1_q)) + 32'(pmp1_q >> 1);
      xf2_q   <= 32'(36'(fmc1_q) * 36'(fmp1_q)) + 32'(fmp1_q >> 1);
    end
  end

  // ---------------- stage 3: divide by 1000 via reciprocal ----------------
  logic        v3_q;
  logic [21:0] req3_q;
  logic        tcc3_q, dss3_q, msrc3_q, pre3_q, fin3_q;
  logic [19:0] fmp3_q;
  logic [15:0] pmc3_q;
  logic [31:0] us_s3_q, us_p3_q, us_f3_q;
  logic [63:0] ps3, pp3, pf3;

  assign ps3 = 64'(xs2_q) * 64'(rtbc_pkg::Div1000Magic);
  assign pp3 = 64'(xp2_q) * 64'(rtbc_pkg::Div1000Magic);
  assign pf3 = 64'(xf2_q) * 64'(rtbc_pkg::Div1000Magic);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req3_q  <= req2_q;
      tcc3_q  <= tcc2_q;
      dss3_q  <= dss2_q;
      msrc3_q <= msrc2_q;
      pre3_q  <= pre2_q;
      fin3_q  <= fin2_q;
      fmp3_q  <= fmp2_q;
      pmc3_q  <= pmc2_q;
      us_s3_q <= 32'(ps3[63:38]);
      us_p3_q <= 32'(pp3[63:38]);
      us_f3_q <= 32'(pf3[63:38]);
    end
  end

  // ---------------- stage 4: overhead sums and status ----------------
  logic        v4_q;
  sb_t         sb4_q, sb4_d;
  logic [21:0] diff4_q, diff4_d;
  logic [31:0] shared4, used4;

  always_comb begin
    shared4 = 32'd0;
    if (tcc3_q) begin
      shared4 = shared4 + us_s3_q + rtbc_pkg::TccUs;
    end
    if (dss3_q) begin
      shared4 = shared4 + ((us_s3_q + rtbc_pkg::DssUs) << 1);
    end else if (msrc3_q) begin
      shared4 = shared4 + us_s3_q + rtbc_pkg::MsrcUs;
    end
    if (pre3_q) begin
      shared4 = shared4 + us_p3_q + rtbc_pkg::PreUs;
    end
    used4 = rtbc_pkg::UsedFixedUs + shared4;

    sb4_d.cur = rtbc_pkg::CurFixedUs + shared4;
    if (fin3_q) begin
      sb4_d.cur = sb4_d.cur + us_f3_q + rtbc_pkg::FinalUs;
    end
    sb4_d.pre       = pre3_q;
    sb4_d.pre_mclks = pmc3_q;
    sb4_d.mp        = fmp3_q;
    sb4_d.mp_zero   = (fmp3_q == 20'd0);
    sb4_d.wr        = 1'b0;
    sb4_d.status    = rtbc_pkg::ST_OK;
    diff4_d         = 22'(32'(req3_q) - used4);
    if (req3_q > rtbc_pkg::MaxBudgetUs) begin
      sb4_d.status = rtbc_pkg::ST_LARGE;
    end else if (req3_q < rtbc_pkg::MinBudgetUs) begin
      sb4_d.status = rtbc_pkg::ST_LOW;
    end else if (fin3_q) begin
      if (used4 > 32'(req3_q)) begin
        sb4_d.status = rtbc_pkg::ST_OVER;
      end else begin
        sb4_d.wr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb4_q   <= sb4_d;
      diff4_q <= diff4_d;
    end
  end

  // ---------------- stage 5: dividend ----------------
  logic        v5_q;
  sb_t         sb5_q;
  logic [31:0] dvd5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb5_q  <= sb4_q;
      dvd5_q <= 32'(32'(diff4_q) * 32'd1000) + 32'(sb4_q.mp >> 1);
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic        dv_q  [NDiv];
  sb_t         dsb_q [NDiv];
  logic [19:0] drem_q[NDiv];
  logic [31:0] ddq_q [NDiv];

  for (genvar i = 0; i < NDiv; i++) begin : g_div
    logic        v_in;
    sb_t         sb_in;
    logic [19:0] rem_in;
    logic [31:0] dq_in;
    logic [20:0] trial;
    logic        qbit;

    if (i == 0) begin : g_first
      assign v_in   = v5_q;
      assign sb_in  = sb5_q;
      assign rem_in = 20'd0;
      assign dq_in  = dvd5_q;
    end else begin : g_next
      assign v_in   = dv_q[i-1];
      assign sb_in  = dsb_q[i-1];
      assign rem_in = drem_q[i-1];
      assign dq_in  = ddq_q[i-1];
    end

    assign trial = {rem_in, dq_in[31]};
    assign qbit  = (trial >= {1'b0, sb_in.mp});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= 1'b0;
      end else if (adv) begin
        dv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dsb_q[i]  <= sb_in;
        drem_q[i] <= qbit ? 20'(trial - {1'b0, sb_in.mp}) : trial[19:0];
        ddq_q[i]  <= {dq_in[30:0], qbit};
      end
    end
  end

  // ---------------- output stage: add pre-range, encode ----------------
  sb_t         sbo;
  logic [15:0] mo;

  assign sbo = dsb_q[NDiv-1];

  always_comb begin
    mo = sbo.mp_zero ? 16'hFFFF : ddq_q[NDiv-1][15:0];
    if (sbo.pre) begin
      mo = mo + sbo.pre_mclks;
    end
  end

  logic [1:0]  status_q;
  logic        wr_q;
  logic [15:0] word_q;
  logic [31:0] cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[NDiv-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= sbo.status;
      wr_q     <= sbo.wr;
      word_q   <= sbo.wr ? rtbc_pkg::encode_word(mo) : 16'd0;
      cur_q    <= sbo.cur;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign write_valid_o       = wr_q;
  assign new_final_word_o    = word_q;
  assign current_budget_us_o = cur_q;

endmodule

// File: hdl/rtbc_checker.sv
// Port-level checker for the ranging timing budget calculator, with its bind.
// Depends on rtbc_pkg for status codes.
module rtbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        write_valid_o,
  input logic [15:0] new_final_word_o,
  input logic [31:0] current_budget_us_o
);

  // Input is held off only while a finished result is being held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a held result");

  // A new word only comes with an ok status
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_valid_o) |-> (status_o == rtbc_pkg::ST_OK))
    else $error("timeout word with a failing status");

  // No word means a zero word
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_valid_o) |-> (new_final_word_o == 16'd0))
    else $error("word not zero without write");

  // A held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(new_final_word_o)
       && $stable(current_budget_us_o) && $stable(write_valid_o)))
    else $error("held result changed");

endmodule

bind ranging_timing_budget_calc_unit rtbc_checker u_rtbc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .status_o            (status_o),
  .write_valid_o       (write_valid_o),
  .new_final_word_o    (new_final_word_o),
  .current_budget_us_o (current_budget_us_o)
);
